[rtl/core/rfd_pkg.sv]
// Package for the route forward decision block: field widths, stream packing
// offsets, command, action and register codes, table entry types and the prefix mask.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rfd_pkg;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 10;
	localparam int IP_W    = 32;
	localparam int TTL_W   = 8;
	localparam int LEN_W   = 6;
	localparam int PORT_W  = 4;
	localparam int MAC_W   = 48;
	localparam int ACT_W   = 3;
	localparam int RCNT_W  = 11;
	localparam int ACNT_W  = 5;
	localparam int CFG_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam int OFF_ENTRY_INDEX = 0;
	localparam int OFF_DEST_IP     = 10;
	localparam int OFF_TTL         = 42;
	localparam int OFF_PREFIX      = 50;
	localparam int OFF_MASK_LEN    = 82;
	localparam int OFF_NEXT_HOP    = 88;
	localparam int OFF_PORT        = 120;
	localparam int OFF_ARP_IP      = 124;
	localparam int OFF_ARP_MAC     = 156;
	localparam int S_TDATA_W       = 208;

	localparam int OFF_OUT_PORT = 0;
	localparam int OFF_NEXT_MAC = 4;
	localparam int OFF_NEW_TTL  = 52;
	localparam int M_TDATA_W    = 64;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ROUTE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ARP    = 2'd2;

	localparam logic [ACT_W-1:0] ACT_FORWARD       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_UNREACH       = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TIME_EXCEEDED = 3'd2;
	localparam logic [ACT_W-1:0] ACT_NO_ARP        = 3'd3;
	localparam logic [ACT_W-1:0] ACT_WRITE_DONE    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARP_COUNT   = 1'b1;

	localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

	typedef struct packed {
		logic [IP_W-1:0]   prefix;
		logic [LEN_W-1:0]  len;
		logic [IP_W-1:0]   hop;
		logic [PORT_W-1:0] port;
	} route_entry_t;

	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} arp_entry_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IP_W-1:0]  dest_ip;
		logic [TTL_W-1:0] ttl;
	} rfd_req_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PORT_W-1:0] out_port;
		logic [MAC_W-1:0]  next_mac;
		logic [TTL_W-1:0]  new_ttl;
	} rfd_res_t;

	function automatic logic [IP_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [IP_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else begin
			m = {IP_W{1'b1}} << (MAX_LEN - len);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[rtl/core/rfd_route_mem.sv]
// Route table memory: one write port and one registered read port.
// Depends on rfd_pkg for the route entry type.
`default_nettype none
module rfd_route_mem
	import rfd_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic         clk,
	input  wire logic         we,
	input  wire logic [AW-1:0] waddr,
	input  wire route_entry_t wdata,
	input  wire logic         re,
	input  wire logic [AW-1:0] raddr,
	output route_entry_t      rdata
);

	route_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/rfd_arp_mem.sv]
// ARP table memory: one write port and one registered read port.
// Depends on rfd_pkg for the ARP entry type.
`default_nettype none
module rfd_arp_mem
	import rfd_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic         clk,
	input  wire logic         we,
	input  wire logic [AW-1:0] waddr,
	input  wire arp_entry_t   wdata,
	input  wire logic         re,
	input  wire logic [AW-1:0] raddr,
	output arp_entry_t        rdata
);

	arp_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/rfd_engine.sv]
// Lookup sequencer: scans the route table one entry a cycle through a single mask and compare
// unit, then, for a found route with a TTL above 1, scans the ARP table for its next hop.
// Depends on rfd_pkg; reads rfd_route_mem and rfd_arp_mem.
`default_nettype none
module rfd_engine
	import rfd_pkg::*;
#(
	parameter int RI_W  = 10,
	parameter int AI_W  = 4,
	parameter int CNT_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire rfd_req_t         req,
	input  wire logic [CNT_W-1:0] nr,
	input  wire logic [CNT_W-1:0] na,
	output logic                  route_re,
	output logic [RI_W-1:0]       route_raddr,
	input  wire route_entry_t     route_rdata,
	output logic                  arp_re,
	output logic [AI_W-1:0]       arp_raddr,
	input  wire arp_entry_t       arp_rdata,
	output logic                  idle,
	output logic                  res_valid,
	input  wire logic             res_take,
	output rfd_res_t              res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUTE = 2'd1;
	localparam logic [1:0] ST_ARP   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] nr_q;
	logic [CNT_W-1:0] na_q;
	logic             rd_pend_q;
	logic [IP_W-1:0]  dest_q;
	logic [TTL_W-1:0] ttl_q;
	logic             found_q;
	logic [LEN_W-1:0] best_len_q;
	logic [IP_W-1:0]  best_hop_q;
	logic [PORT_W-1:0] best_port_q;
	logic             hit_q;
	logic [MAC_W-1:0] mac_q;
	rfd_res_t         res_q;

	logic issue_r;
	logic issue_a;
	logic match;
	logic better;

	assign issue_r = (state_q == ST_ROUTE) && (cnt_q < nr_q);
	assign issue_a = (state_q == ST_ARP) && (cnt_q < na_q) && !hit_q;
	assign match   = ((route_rdata.prefix ^ dest_q) & prefix_mask(route_rdata.len)) == '0;
	assign better  = match && (!found_q || (route_rdata.len > best_len_q));

	assign route_re    = issue_r;
	assign route_raddr = cnt_q[RI_W-1:0];
	assign arp_re      = issue_a;
	assign arp_raddr   = cnt_q[AI_W-1:0];
	assign idle        = (state_q == ST_IDLE);
	assign res_valid   = (state_q == ST_DONE);
	assign res         = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_pend_q <= 1'b0;
			found_q   <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q     <= '0;
						rd_pend_q <= 1'b0;
						found_q   <= 1'b0;
						hit_q     <= 1'b0;
						if (req.cmd == CMD_LOOKUP) begin
							state_q <= ST_ROUTE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_ROUTE: begin
					rd_pend_q <= issue_r;
					if (issue_r) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_pend_q && better) begin
						found_q <= 1'b1;
					end
					if (!rd_pend_q && !issue_r) begin
						cnt_q <= '0;
						if (!found_q || (ttl_q <= 8'd1)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ARP;
						end
					end
				end
				ST_ARP: begin
					rd_pend_q <= issue_a;
					if (issue_a) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_pend_q && !hit_q && (arp_rdata.ip == best_hop_q)) begin
						hit_q <= 1'b1;
					end
					if (!rd_pend_q && !issue_a) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					dest_q <= req.dest_ip;
					ttl_q  <= req.ttl;
					nr_q   <= nr;
					na_q   <= na;
					res_q  <= '{action: ACT_WRITE_DONE, out_port: '0, next_mac: '0,
						new_ttl: req.ttl};
				end
			end
			ST_ROUTE: begin
				if (rd_pend_q && better) begin
					best_len_q  <= route_rdata.len;
					best_hop_q  <= route_rdata.hop;
					best_port_q <= route_rdata.port;
				end
				if (!rd_pend_q && !issue_r) begin
					if (!found_q) begin
						res_q.action <= ACT_UNREACH;
					end else if (ttl_q <= 8'd1) begin
						res_q.action <= ACT_TIME_EXCEEDED;
					end
				end
			end
			ST_ARP: begin
				if (rd_pend_q && !hit_q && (arp_rdata.ip == best_hop_q)) begin
					mac_q <= arp_rdata.mac;
				end
				if (!rd_pend_q && !issue_a) begin
					if (hit_q) begin
						res_q <= '{action: ACT_FORWARD, out_port: best_port_q,
							next_mac: mac_q, new_ttl: ttl_q - 8'd1};
					end else begin
						res_q.action <= ACT_NO_ARP;
					end
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/route_forward_decision_top.sv]
// Route forward decision engine: longest prefix match over a route table,
// then next-hop lookup in an ARP table.
//
// Input channel s_*: one transaction carries a command in s_tuser. A lookup
// takes dest_ip and ttl; a route or ARP write stores its operands in slot
// entry_index, if it is in range, at the edge the transaction is accepted.
// Output channel m_*: exactly one result transaction per input transaction,
// the action in m_tuser and port, MAC and new TTL in m_tdata.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 route count,
// 1 ARP count) at the clock edge. The user must write only while no
// transaction is in flight; the block does not enforce it. After a write is
// accepted the engine enters its done state, and m_tvalid rises once the
// result is loaded into the output register. A lookup scans nr route and up
// to na ARP entries, the route and ARP counts in use: the single compare
// unit visits one table entry a cycle through the registered memory read
// port, and the ARP scan stops at its first hit. s_tready is low from
// acceptance until the result is loaded into the output register, so one
// transaction is in flight at a time. When the receiver stalls, the result
// holds in the output register and the next result waits. Reset clears
// both counts and all control; table contents stay undefined until written.
`default_nettype none
module route_forward_decision_top
	import rfd_pkg::*;
#(
	parameter int ROUTES      = 1024,
	parameter int ARP_ENTRIES = 16,
	parameter int PORTS       = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// entry_index, dest_ip, ttl, route_prefix, route_mask_len, route_next_hop,
	// route_port, arp_ip, arp_mac, zero fill
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// command
	input  wire logic [CMD_W-1:0]     s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_port, next_mac, new_ttl, zero fill
	output logic [M_TDATA_W-1:0]      m_tdata,
	// action
	output logic [ACT_W-1:0]          m_tuser,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int RI_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam int AI_W  = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
	localparam int RC_W  = $clog2(ROUTES + 1);
	localparam int AC_W  = $clog2(ARP_ENTRIES + 1);
	localparam int CNT_W = (RC_W > AC_W) ? RC_W : AC_W;

	logic [RCNT_W-1:0] route_count_q;
	logic [ACNT_W-1:0] arp_count_q;
	logic              m_tvalid_q;
	rfd_res_t          m_res_q;

	logic              accept;
	logic [IDX_W-1:0]  entry_index;
	logic              route_we;
	logic              arp_we;
	route_entry_t      route_wdata;
	arp_entry_t        arp_wdata;
	logic [LEN_W-1:0]  in_len;
	logic [PORT_W-1:0] in_port;
	rfd_req_t          req;
	logic [CNT_W-1:0]  nr;
	logic [CNT_W-1:0]  na;

	logic              route_re;
	logic [RI_W-1:0]   route_raddr;
	route_entry_t      route_rdata;
	logic              arp_re;
	logic [AI_W-1:0]   arp_raddr;
	arp_entry_t        arp_rdata;
	logic              eng_idle;
	logic              res_valid;
	logic              res_take;
	rfd_res_t          res;

	assign accept      = s_tvalid && s_tready;
	assign s_tready    = eng_idle;
	assign entry_index = s_tdata[OFF_ENTRY_INDEX +: IDX_W];

	assign in_len  = (s_tdata[OFF_MASK_LEN +: LEN_W] > MAX_LEN) ? MAX_LEN
		: s_tdata[OFF_MASK_LEN +: LEN_W];
	assign in_port = (32'(s_tdata[OFF_PORT +: PORT_W]) >= PORTS) ? PORT_W'(PORTS - 1)
		: s_tdata[OFF_PORT +: PORT_W];

	assign route_we = accept && (s_tuser == CMD_ROUTE) && (32'(entry_index) < ROUTES);
	assign arp_we   = accept && (s_tuser == CMD_ARP) && (32'(entry_index) < ARP_ENTRIES);

	assign route_wdata = '{prefix: s_tdata[OFF_PREFIX +: IP_W], len: in_len,
		hop: s_tdata[OFF_NEXT_HOP +: IP_W], port: in_port};
	assign arp_wdata   = '{ip: s_tdata[OFF_ARP_IP +: IP_W], mac: s_tdata[OFF_ARP_MAC +: MAC_W]};

	assign req = '{cmd: s_tuser, dest_ip: s_tdata[OFF_DEST_IP +: IP_W],
		ttl: s_tdata[OFF_TTL +: TTL_W]};

	assign nr = (32'(route_count_q) > ROUTES) ? CNT_W'(ROUTES) : CNT_W'(route_count_q);
	assign na = (32'(arp_count_q) > ARP_ENTRIES) ? CNT_W'(ARP_ENTRIES) : CNT_W'(arp_count_q);

	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
			arp_count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROUTE_COUNT: route_count_q <= cfg_data[RCNT_W-1:0];
				CFG_ARP_COUNT:   arp_count_q   <= cfg_data[ACNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_res_q.action;
	assign m_tdata  = {4'd0, m_res_q.new_ttl, m_res_q.next_mac, m_res_q.out_port};

	rfd_route_mem #(
		.DEPTH(ROUTES),
		.AW   (RI_W)
	) u_route_mem (
		.clk  (clk),
		.we   (route_we),
		.waddr(RI_W'(entry_index)),
		.wdata(route_wdata),
		.re   (route_re),
		.raddr(route_raddr),
		.rdata(route_rdata)
	);

	rfd_arp_mem #(
		.DEPTH(ARP_ENTRIES),
		.AW   (AI_W)
	) u_arp_mem (
		.clk  (clk),
		.we   (arp_we),
		.waddr(AI_W'(entry_index)),
		.wdata(arp_wdata),
		.re   (arp_re),
		.raddr(arp_raddr),
		.rdata(arp_rdata)
	);

	rfd_engine #(
		.RI_W (RI_W),
		.AI_W (AI_W),
		.CNT_W(CNT_W)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.req        (req),
		.nr         (nr),
		.na         (na),
		.route_re   (route_re),
		.route_raddr(route_raddr),
		.route_rdata(route_rdata),
		.arp_re     (arp_re),
		.arp_raddr  (arp_raddr),
		.arp_rdata  (arp_rdata),
		.idle       (eng_idle),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

endmodule
`default_nettype wire

[rtl/core/rfd_chk.sv]
// Port-level checker for route_forward_decision_top and its bind statement.
// Depends on rfd_pkg for codes and output field offsets.
`default_nettype none
module rfd_chk
	import rfd_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [CMD_W-1:0]     s_tuser,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [ACT_W-1:0]     m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled output transaction changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted while a transaction is in flight.");

	a_write_answer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != CMD_LOOKUP) && !m_tvalid
		|=> ##1 (m_tvalid && (m_tuser == ACT_WRITE_DONE)))
		else $error("Write command did not answer write done in time.");

	a_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ACT_FORWARD) |-> m_tdata[OFF_NEW_TTL-1:0] == '0)
		else $error("Non-forward result carries port or MAC.");

	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_FORWARD) |-> m_tdata[OFF_NEW_TTL +: TTL_W] != '0)
		else $error("Forwarded with an expired TTL.");

endmodule

bind route_forward_decision_top rfd_chk u_rfd_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire
